// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold at every clock edge
`define ITF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define ITF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg
// shared types, codes and character constants of the integer text formatter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itf_pkg;

    localparam int VALUE_W                = 64;
    localparam int DEFAULT_MAX_FIELD      = 62;
    localparam int DEFAULT_DIGIT_CAPACITY = 22;

    // decimal conversion shifts two value bits per cycle
    localparam int CONV_STEPS = VALUE_W / 2;
    localparam int CONV_CNT_W = $clog2(CONV_STEPS);

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 8;

    // radix codes, the unused code reads as decimal
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;

    // unsigned prefix codes
    localparam logic [1:0] PREFIX_NONE      = 2'd0;
    localparam logic [1:0] PREFIX_HEX_LOWER = 2'd1;
    localparam logic [1:0] PREFIX_HEX_UPPER = 2'd2;
    localparam logic [1:0] PREFIX_OCTAL     = 2'd3;

    // output phase codes, controller to datapath
    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_PREFIX = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGIT  = 2'd3;

    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [3:0] DEC_BASE     = 4'd10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               signed_mode;
        logic [1:0]         radix;
        logic               upper_case;
        logic [5:0]         field_width;
        logic [5:0]         precision;
        logic               has_precision;
        logic               left_justify;
        logic               force_plus;
        logic               space_sign;
        logic               zero_pad;
        logic [1:0]         prefix_kind;
    } item_t;

    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       norm_step;
        logic       plan;
        logic       emit;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic dec;
        logic conv_last;
        logic norm_done;
        logic left;
        logic sp_zero;
        logic pre_zero;
        logic pad_zero;
        logic nd_zero;
        logic slot_free;
    } stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < DEC_BASE)
        begin
            c = CHAR_ZERO + {4'h0, d};
        end
        else
        begin
            c = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'h0, d} - {4'h0, DEC_BASE};
        end
        return c;
    endfunction

endpackage

// ===== rtl/itf_ctrl.sv =====
// ----------------------------------------------------------------------------
// itf_ctrl
// sequencer: load, decimal conversion, zero skip, layout, character output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itf_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  itf_pkg::stat_t stat,
    output itf_pkg::cmd_t  cmd
);
    import itf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CONV = 4'd1;
    localparam logic [3:0] S_NORM = 4'd2;
    localparam logic [3:0] S_PLAN = 4'd3;
    localparam logic [3:0] S_LSP  = 4'd4;
    localparam logic [3:0] S_PRE  = 4'd5;
    localparam logic [3:0] S_ZERO = 4'd6;
    localparam logic [3:0] S_DIG  = 4'd7;
    localparam logic [3:0] S_TSP  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.phase  = PH_SPACE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (!stat.dec)
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    cmd.conv_step = 1'b1;
                    if (stat.conv_last)
                    begin
                        state_next = S_NORM;
                    end
                end
            end
            S_NORM:
            begin
                if (stat.norm_done)
                begin
                    state_next = S_PLAN;
                end
                else
                begin
                    cmd.norm_step = 1'b1;
                end
            end
            S_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = S_LSP;
            end
            S_LSP:
            begin
                cmd.phase = PH_SPACE;
                if (stat.left || stat.sp_zero)
                begin
                    state_next = S_PRE;
                end
                else
                begin
                    cmd.emit = stat.slot_free;
                end
            end
            S_PRE:
            begin
                cmd.phase = PH_PREFIX;
                if (stat.pre_zero)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    cmd.emit = stat.slot_free;
                end
            end
            S_ZERO:
            begin
                cmd.phase = PH_ZERO;
                if (stat.pad_zero)
                begin
                    state_next = S_DIG;
                end
                else
                begin
                    cmd.emit = stat.slot_free;
                end
            end
            S_DIG:
            begin
                cmd.phase = PH_DIGIT;
                if (stat.nd_zero)
                begin
                    state_next = S_TSP;
                end
                else
                begin
                    cmd.emit = stat.slot_free;
                end
            end
            S_TSP:
            begin
                cmd.phase = PH_SPACE;
                if (!stat.left || stat.sp_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit = stat.slot_free;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/itf_dpath.sv =====
// ----------------------------------------------------------------------------
// itf_dpath
// digit register, layout counters and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itf_dpath
#(
    parameter int MAX_FIELD      = itf_pkg::DEFAULT_MAX_FIELD,
    parameter int DIGIT_CAPACITY = itf_pkg::DEFAULT_DIGIT_CAPACITY
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  itf_pkg::item_t item,
    input  itf_pkg::cmd_t  cmd,
    output itf_pkg::stat_t stat,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_char,
    output logic           out_last
);
    import itf_pkg::*;

    localparam int DB    = 4 * DIGIT_CAPACITY;
    localparam int ND_W  = $clog2(DIGIT_CAPACITY + 1);
    localparam int CNT_W = $clog2(DIGIT_CAPACITY + MAX_FIELD + 3);

    // one bcd adjust-and-shift step of the double dabble
    function automatic logic [DB-1:0] dabble(input logic [DB-1:0] b, input logic bin);
        logic [DB-1:0] a;
        a = b;
        for (int i = 0; i < DIGIT_CAPACITY; i++)
        begin
            if (b[4*i +: 4] >= 4'd5)
            begin
                a[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return {a[DB-2:0], bin};
    endfunction

    // control registers
    logic                  out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]      sp_reg, sp_next;
    logic [CNT_W-1:0]      pad_reg, pad_next;
    logic [CNT_W-1:0]      tot_reg, tot_next;
    logic [1:0]            plen_reg, plen_next;
    logic [ND_W-1:0]       nd_reg, nd_next;
    logic [CONV_CNT_W-1:0] conv_cnt_reg, conv_cnt_next;

    // payload registers
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [DB-1:0]      dig_reg, dig_next;
    logic [7:0]         pre0_reg, pre0_next;
    logic [7:0]         pre1_reg, pre1_next;
    logic [5:0]         width_reg, width_next;
    logic [5:0]         prec_reg, prec_next;
    logic               has_prec_reg, has_prec_next;
    logic               left_reg, left_next;
    logic               zpad_reg, zpad_next;
    logic               upper_reg, upper_next;
    logic               dec_reg, dec_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;

    // load-side logic
    logic               neg;
    logic [VALUE_W-1:0] mag_load;
    logic [DB-1:0]      ext;
    logic [DB-1:0]      hex_dig;
    logic [DB-1:0]      oct_dig;
    logic               is_hex;
    logic               is_oct;
    logic [7:0]         pre0_load;
    logic [7:0]         pre1_load;
    logic [1:0]         plen_load;

    // layout logic
    logic [CNT_W-1:0] nd_c, w_c, p_c, pl_c;
    logic [CNT_W-1:0] pad_calc, used_calc, sp_calc, tot_calc;

    logic [3:0] top_digit;
    logic [7:0] emit_char;
    logic       slot_free;

    assign neg      = item.signed_mode && item.value[VALUE_W-1];
    assign mag_load = neg ? (~item.value + VALUE_W'(1)) : item.value;
    assign ext      = DB'(mag_load);
    assign is_hex   = (item.radix == RADIX_HEX);
    assign is_oct   = (item.radix == RADIX_OCT);

    always_comb
    begin
        hex_dig = '0;
        oct_dig = '0;
        for (int i = 0; i < DIGIT_CAPACITY; i++)
        begin
            hex_dig[4*i +: 4] = ext[4*i +: 4];
            oct_dig[4*i +: 4] = {1'b0, ext[3*i +: 3]};
        end
    end

    // sign or radix prefix
    always_comb
    begin
        pre0_load = CHAR_ZERO;
        pre1_load = CHAR_LOWER_X;
        plen_load = 2'd0;
        if (item.signed_mode)
        begin
            if (neg)
            begin
                pre0_load = CHAR_MINUS;
                plen_load = 2'd1;
            end
            else if (item.force_plus)
            begin
                pre0_load = CHAR_PLUS;
                plen_load = 2'd1;
            end
            else if (item.space_sign)
            begin
                pre0_load = CHAR_SPACE;
                plen_load = 2'd1;
            end
        end
        else
        begin
            case (item.prefix_kind)
                PREFIX_HEX_LOWER: plen_load = 2'd2;
                PREFIX_HEX_UPPER:
                begin
                    pre1_load = CHAR_UPPER_X;
                    plen_load = 2'd2;
                end
                PREFIX_OCTAL:     plen_load = 2'd1;
                default:          plen_load = 2'd0;
            endcase
        end
    end

    // pad and space counts from the digit count
    always_comb
    begin
        nd_c     = CNT_W'(nd_reg);
        w_c      = CNT_W'(width_reg);
        p_c      = CNT_W'(prec_reg);
        pl_c     = CNT_W'(plen_reg);
        pad_calc = '0;
        if (has_prec_reg)
        begin
            if (p_c > nd_c)
            begin
                pad_calc = p_c - nd_c;
            end
        end
        else if (zpad_reg && !left_reg)
        begin
            if (w_c > nd_c + pl_c)
            begin
                pad_calc = w_c - nd_c - pl_c;
            end
        end
        used_calc = nd_c + pl_c + pad_calc;
        sp_calc   = (w_c > used_calc) ? (w_c - used_calc) : '0;
        tot_calc  = used_calc + sp_calc;
    end

    assign top_digit = dig_reg[DB-1 -: 4];
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.phase)
            PH_SPACE:  emit_char = CHAR_SPACE;
            PH_PREFIX: emit_char = pre0_reg;
            PH_ZERO:   emit_char = CHAR_ZERO;
            PH_DIGIT:  emit_char = digit_char(top_digit, upper_reg);
            default:   emit_char = CHAR_SPACE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sp_next        = sp_reg;
        pad_next       = pad_reg;
        tot_next       = tot_reg;
        plen_next      = plen_reg;
        nd_next        = nd_reg;
        conv_cnt_next  = conv_cnt_reg;
        mag_next       = mag_reg;
        dig_next       = dig_reg;
        pre0_next      = pre0_reg;
        pre1_next      = pre1_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        has_prec_next  = has_prec_reg;
        left_next      = left_reg;
        zpad_next      = zpad_reg;
        upper_next     = upper_reg;
        dec_next       = dec_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (cmd.load)
        begin
            mag_next      = mag_load;
            dig_next      = is_hex ? hex_dig : (is_oct ? oct_dig : '0);
            dec_next      = !(is_hex || is_oct);
            pre0_next     = pre0_load;
            pre1_next     = pre1_load;
            plen_next     = plen_load;
            width_next    = (item.field_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD)
                                                               : item.field_width;
            prec_next     = (item.precision > 6'(MAX_FIELD)) ? 6'(MAX_FIELD)
                                                             : item.precision;
            has_prec_next = item.has_precision;
            left_next     = item.left_justify;
            zpad_next     = item.zero_pad;
            upper_next    = item.upper_case;
            nd_next       = ND_W'(DIGIT_CAPACITY);
            conv_cnt_next = '0;
        end

        if (cmd.conv_step)
        begin
            dig_next      = dabble(dabble(dig_reg, mag_reg[VALUE_W-1]), mag_reg[VALUE_W-2]);
            mag_next      = {mag_reg[VALUE_W-3:0], 2'b00};
            conv_cnt_next = conv_cnt_reg + CONV_CNT_W'(1);
        end

        if (cmd.norm_step)
        begin
            dig_next = {dig_reg[DB-5:0], 4'h0};
            nd_next  = nd_reg - ND_W'(1);
        end

        if (cmd.plan)
        begin
            pad_next = pad_calc;
            sp_next  = sp_calc;
            tot_next = tot_calc;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = (tot_reg == CNT_W'(1));
            tot_next       = tot_reg - CNT_W'(1);
            case (cmd.phase)
                PH_SPACE:  sp_next = sp_reg - CNT_W'(1);
                PH_PREFIX:
                begin
                    pre0_next = pre1_reg;
                    plen_next = plen_reg - 2'd1;
                end
                PH_ZERO:   pad_next = pad_reg - CNT_W'(1);
                PH_DIGIT:
                begin
                    dig_next = {dig_reg[DB-5:0], 4'h0};
                    nd_next  = nd_reg - ND_W'(1);
                end
                default:   sp_next = sp_reg;
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sp_reg        <= '0;
            pad_reg       <= '0;
            tot_reg       <= '0;
            plen_reg      <= '0;
            nd_reg        <= '0;
            conv_cnt_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sp_reg        <= sp_next;
            pad_reg       <= pad_next;
            tot_reg       <= tot_next;
            plen_reg      <= plen_next;
            nd_reg        <= nd_next;
            conv_cnt_reg  <= conv_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        dig_reg      <= dig_next;
        pre0_reg     <= pre0_next;
        pre1_reg     <= pre1_next;
        width_reg    <= width_next;
        prec_reg     <= prec_next;
        has_prec_reg <= has_prec_next;
        left_reg     <= left_next;
        zpad_reg     <= zpad_next;
        upper_reg    <= upper_next;
        dec_reg      <= dec_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign stat.dec       = dec_reg;
    assign stat.conv_last = (conv_cnt_reg == CONV_CNT_W'(CONV_STEPS - 1));
    assign stat.norm_done = (top_digit != 4'h0) || (nd_reg == ND_W'(1));
    assign stat.left      = left_reg;
    assign stat.sp_zero   = (sp_reg == '0);
    assign stat.pre_zero  = (plen_reg == 2'd0);
    assign stat.pad_zero  = (pad_reg == '0);
    assign stat.nd_zero   = (nd_reg == '0);
    assign stat.slot_free = slot_free;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    `ITF_ASSERT_IMP(a_emit_slot, cmd.emit, slot_free, "character emitted into a full output register")
    `ITF_ASSERT_IMP(a_emit_total, cmd.emit, tot_reg != '0, "character emitted past the planned total")
    `ITF_ASSERT_IMP(a_digit_avail, cmd.emit && (cmd.phase == PH_DIGIT), nd_reg != '0, "digit emitted with none left")
    `ITF_ASSERT_IMP(a_trailing_total, cmd.emit && (cmd.phase == PH_SPACE) && (nd_reg == '0), tot_reg == sp_reg, "trailing spaces disagree with remaining total")
    `ITF_ASSERT_IMP(a_skip_zero, cmd.norm_step, top_digit == 4'h0, "leading digit skipped while nonzero")

endmodule

// ===== rtl/integer_text_formatter_core.sv =====
// ----------------------------------------------------------------------------
// integer_text_formatter_core
// printf-style integer conversion of one 64-bit value to a stream of ascii
// ----------------------------------------------------------------------------
// One input item carries a 64-bit value and its conversion settings; the
// block answers with the formatted text, one ascii character per output item,
// with tlast on the final character (1 to 64 characters per value). Items are
// handled one at a time: a new value is taken only once the previous text has
// been handed to the output register. Decimal digits come from double dabble
// at two value bits per cycle; hex and octal digits are bit slices. Leading
// zero digits are then skipped one per cycle (digit capacity minus the digit
// count, at most 21 by default), and the characters go out one per cycle
// through the single output register while tready is held high.
`timescale 1ns / 1ps

module integer_text_formatter_core
#(
    parameter int MAX_FIELD      = itf_pkg::DEFAULT_MAX_FIELD,
    parameter int DIGIT_CAPACITY = itf_pkg::DEFAULT_DIGIT_CAPACITY
)
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // value[63:0], radix[65:64], upper_case[66], field_width[72:67],
    // precision[78:73], has_precision[79], left_justify[80], force_plus[81],
    // space_sign[82], zero_pad[83], prefix_kind[85:84], zero fill[87:86]
    input  logic [itf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // signed_mode[0]
    input  logic [0:0]                       s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_char[7:0]
    output logic [itf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);
    import itf_pkg::*;

    item_t item;
    cmd_t  cmd;
    stat_t stat;

    // unpack the input item; the datapath only samples it on a load command
    always_comb
    begin
        item.value         = s_axis_tdata[63:0];
        item.signed_mode   = s_axis_tuser[0];
        item.radix         = s_axis_tdata[65:64];
        item.upper_case    = s_axis_tdata[66];
        item.field_width   = s_axis_tdata[72:67];
        item.precision     = s_axis_tdata[78:73];
        item.has_precision = s_axis_tdata[79];
        item.left_justify  = s_axis_tdata[80];
        item.force_plus    = s_axis_tdata[81];
        item.space_sign    = s_axis_tdata[82];
        item.zero_pad      = s_axis_tdata[83];
        item.prefix_kind   = s_axis_tdata[85:84];
    end

    // sequencer: accept, convert, skip leading zeros, lay out, emit
    itf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // digits, prefix, pad and space counters, output register
    itf_dpath
    #(
        .MAX_FIELD      (MAX_FIELD),
        .DIGIT_CAPACITY (DIGIT_CAPACITY)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== tb/sv/integer_text_formatter_core_tb.sv =====
// ----------------------------------------------------------------------------
// integer_text_formatter_core_tb
// self-checking bench for the printf-style integer text formatter
// ----------------------------------------------------------------------------
// A short table of directed values is sent first. Rows with an obvious answer
// carry their text typed in, and the other rows go through the local
// formatter model. After the table come random values with random settings.
// Both stream sides idle at random. The output side holds off once for a long
// stretch, and the sender drains the block once. Every character and its
// tlast are compared against the queued expected text.
`timescale 1ns / 1ps

module integer_text_formatter_core_tb;

    import itf_pkg::*;

    localparam int FIELD_LIMIT  = DEFAULT_MAX_FIELD;
    localparam int DIGIT_LIMIT  = DEFAULT_DIGIT_CAPACITY;
    localparam int RANDOM_ITEMS = 336;
    localparam int HOLD_AT      = 40;     // accepted items before the output hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int PAUSE_AT     = 120;    // random item where the sender drains the block
    localparam int STEADY_FROM  = 200;    // random items run with no idling on either side
    localparam int STEADY_TO    = 260;
    localparam int DRAIN_CYCLES = 200;    // comfortably above the longest item time
    localparam int CYCLE_LIMIT  = 600000;

    // one expected output character
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic [0:0]              s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;

    text_char_t  expected_text[$];
    text_char_t  want;
    item_t       table_items[$];
    string       table_texts[$];

    int unsigned cycle_count = 0;
    int          error_count = 0;
    int          accepted_items = 0;
    int          chars_checked = 0;
    int          signed_items = 0;
    int          hex_items = 0;
    int          oct_items = 0;
    int          odd_radix_items = 0;
    bit          steady = 1'b0;
    bit          hold_done = 1'b0;

    integer_text_formatter_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog, a hung handshake ends the run here
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d characters still expected",
                 cycle_count, expected_text.size());
        $display("** integer_text_formatter_core: FAILED **");
        $finish;
    end

    // builds one item from table-style arguments
    function automatic item_t make_item(input logic [63:0] v, input bit sgn,
                                        input logic [1:0] rdx, input bit up,
                                        input int w, input int p, input bit hp,
                                        input bit lj, input bit fp, input bit ss,
                                        input bit zp, input logic [1:0] pk);
        item_t it;
        it.value         = v;
        it.signed_mode   = sgn;
        it.radix         = rdx;
        it.upper_case    = up;
        it.field_width   = w[5:0];
        it.precision     = p[5:0];
        it.has_precision = hp;
        it.left_justify  = lj;
        it.force_plus    = fp;
        it.space_sign    = ss;
        it.zero_pad      = zp;
        it.prefix_kind   = pk;
        return it;
    endfunction

    // formats one value and queues its characters, tlast on the final one
    function automatic void format_value(input item_t it);
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] d;
        logic [7:0]  pre [0:1];
        logic [7:0]  digs [0:63];
        logic [7:0]  line [$];
        text_char_t  tc;
        int          w;
        int          p;
        int          plen;
        int          nd;
        int          pad;
        int          sp;
        int          i;

        w    = (it.field_width > FIELD_LIMIT) ? FIELD_LIMIT : int'(it.field_width);
        p    = (it.precision > FIELD_LIMIT) ? FIELD_LIMIT : int'(it.precision);
        mag  = it.value;
        plen = 0;
        nd   = 0;
        pad  = 0;

        // sign prefix in signed mode, chosen prefix otherwise
        if (it.signed_mode)
        begin
            if (mag[63])
            begin
                pre[0] = CHAR_MINUS;
                plen   = 1;
                mag    = ~mag + 64'd1;
            end
            else if (it.force_plus)
            begin
                pre[0] = CHAR_PLUS;
                plen   = 1;
            end
            else if (it.space_sign)
            begin
                pre[0] = CHAR_SPACE;
                plen   = 1;
            end
        end
        else
        begin
            case (it.prefix_kind)
                PREFIX_HEX_LOWER:
                begin
                    pre[0] = CHAR_ZERO;
                    pre[1] = CHAR_LOWER_X;
                    plen   = 2;
                end
                PREFIX_HEX_UPPER:
                begin
                    pre[0] = CHAR_ZERO;
                    pre[1] = CHAR_UPPER_X;
                    plen   = 2;
                end
                PREFIX_OCTAL:
                begin
                    pre[0] = CHAR_ZERO;
                    plen   = 1;
                end
                default:
                begin
                    plen = 0;
                end
            endcase
        end

        // the unused radix code reads as decimal
        case (it.radix)
            RADIX_HEX: base = 64'd16;
            RADIX_OCT: base = 64'd8;
            default:   base = 64'd10;
        endcase

        // digits least significant first, zero still gives one digit
        do
        begin
            d = mag % base;
            if (d < 64'd10)
                digs[nd] = CHAR_ZERO + d[7:0];
            else
                digs[nd] = (it.upper_case ? CHAR_UPPER_A : CHAR_LOWER_A) + d[7:0] - 8'd10;
            nd  = nd + 1;
            mag = mag / base;
        end
        while (mag != 64'd0 && nd < DIGIT_LIMIT);

        // precision wins over zero fill
        if (it.has_precision)
        begin
            if (p > nd)
                pad = p - nd;
        end
        else if (it.zero_pad && !it.left_justify)
        begin
            if (w - nd - plen > 0)
                pad = w - nd - plen;
        end
        sp = w - nd - pad - plen;
        if (sp < 0)
            sp = 0;

        if (!it.left_justify)
            for (i = 0; i < sp; i++)
                line.push_back(CHAR_SPACE);
        for (i = 0; i < plen; i++)
            line.push_back(pre[i]);
        for (i = 0; i < pad; i++)
            line.push_back(CHAR_ZERO);
        for (i = nd - 1; i >= 0; i--)
            line.push_back(digs[i]);
        if (it.left_justify)
            for (i = 0; i < sp; i++)
                line.push_back(CHAR_SPACE);

        for (i = 0; i < line.size(); i++)
        begin
            tc.ch   = line[i];
            tc.last = (i == line.size() - 1);
            expected_text.push_back(tc);
        end
    endfunction

    function automatic item_t random_item();
        item_t       it;
        logic [63:0] v;
        int          pick;

        pick = $urandom_range(0, 9);
        v    = {$urandom, $urandom};
        case (pick)
            4, 5:    v = 64'($urandom_range(0, 1000));
            6:
            begin
                // around zero, the sign boundary and all ones
                case ($urandom_range(0, 3))
                    0:       v = 64'($urandom_range(0, 3));
                    1:       v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
                    2:       v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
                    default: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
                endcase
            end
            7:       v = -64'($urandom_range(1, 1000));
            8, 9:    v = v >> $urandom_range(0, 63);
            default: v = v;
        endcase

        it.value         = v;
        it.signed_mode   = 1'($urandom_range(0, 1));
        it.radix         = 2'($urandom_range(0, 3));
        it.upper_case    = 1'($urandom_range(0, 1));
        it.field_width   = ($urandom_range(0, 99) < 12) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(0, 24));
        it.precision     = ($urandom_range(0, 99) < 12) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(0, 24));
        it.has_precision = 1'($urandom_range(0, 1));
        it.left_justify  = 1'($urandom_range(0, 1));
        it.force_plus    = 1'($urandom_range(0, 1));
        it.space_sign    = 1'($urandom_range(0, 1));
        it.zero_pad      = 1'($urandom_range(0, 1));
        it.prefix_kind   = 2'($urandom_range(0, 3));
        return it;
    endfunction

    // offers one item and queues its text once it is accepted; a non-empty
    // text is taken as typed, otherwise the local formatter supplies it
    task automatic send_item(input item_t it, input string text, input bit may_idle);
        text_char_t tc;
        int         gap;
        int         i;

        gap = (may_idle && !steady && $urandom_range(0, 99) < 30) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.prefix_kind, it.zero_pad, it.space_sign, it.force_plus,
                          it.left_justify, it.has_precision, it.precision, it.field_width,
                          it.upper_case, it.radix, it.value};
        s_axis_tuser  <= it.signed_mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);

        if (text.len() > 0)
        begin
            for (i = 0; i < text.len(); i++)
            begin
                tc.ch   = text[i];
                tc.last = (i == text.len() - 1);
                expected_text.push_back(tc);
            end
        end
        else
        begin
            format_value(it);
        end

        accepted_items++;
        if (it.signed_mode)
            signed_items++;
        case (it.radix)
            RADIX_HEX: hex_items++;
            RADIX_OCT: oct_items++;
            RADIX_DEC: ;
            default:   odd_radix_items++;
        endcase
    endtask

    // output side: random stalls, one long hold-off that backs the block up
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (accepted_items >= HOLD_AT && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // output checker, each character against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("character %h with nothing expected", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (m_axis_tdata !== want.ch)
                begin
                    $error("out_char mismatch: expected %h, got %h", want.ch, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("out_last mismatch: expected %b, got %b", want.last, m_axis_tlast);
                    error_count++;
                end
                chars_checked++;
            end
        end
    end

    initial
    begin
        int k;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;

        // directed rows:  value, signed, radix, upper, width, precision, has_precision,
        //                 left, plus, space, zero_pad, prefix
        table_items.push_back(make_item(64'd0, 0, RADIX_DEC, 0, 0, 0, 0, 0, 0, 0, 0,
                                        PREFIX_NONE));
        table_texts.push_back("0");
        // zero with precision zero still prints one digit
        table_items.push_back(make_item(64'd0, 0, RADIX_DEC, 0, 0, 0, 1, 0, 0, 0, 0,
                                        PREFIX_NONE));
        table_texts.push_back("0");
        table_items.push_back(make_item(64'd0, 0, RADIX_DEC, 0, 0, 5, 1, 0, 0, 0, 0,
                                        PREFIX_NONE));
        table_texts.push_back("");
        table_items.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, 0, RADIX_DEC, 0, 0, 0, 0,
                                        0, 0, 0, 0, PREFIX_NONE));
        table_texts.push_back("18446744073709551615");
        // most negative value, magnitude printed exactly
        table_items.push_back(make_item(64'h8000_0000_0000_0000, 1, RADIX_DEC, 0, 0, 0, 0,
                                        0, 0, 0, 0, PREFIX_NONE));
        table_texts.push_back("-9223372036854775808");
        table_items.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, 1, RADIX_DEC, 0, 0, 0, 0,
                                        0, 0, 0, 0, PREFIX_NONE));
        table_texts.push_back("-1");
        // lower-case 0x prefix whatever the letter case
        table_items.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, 0, RADIX_HEX, 1, 0, 0, 0,
                                        0, 0, 0, 0, PREFIX_HEX_LOWER));
        table_texts.push_back("0xFFFFFFFFFFFFFFFF");
        table_items.push_back(make_item(64'hDEAD_BEEF, 0, RADIX_HEX, 0, 0, 0, 0, 0, 0, 0, 0,
                                        PREFIX_HEX_UPPER));
        table_texts.push_back("0Xdeadbeef");
        table_items.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, 0, RADIX_OCT, 0, 0, 0, 0,
                                        0, 0, 0, 0, PREFIX_OCTAL));
        table_texts.push_back("01777777777777777777777");
        table_items.push_back(make_item(64'h0123_4567_89AB_CDEF, 0, RADIX_HEX, 0, 0, 0, 0,
                                        0, 0, 0, 0, PREFIX_NONE));
        table_texts.push_back("123456789abcdef");
        // radix code three prints decimal
        table_items.push_back(make_item(64'd123, 0, 2'd3, 1, 0, 0, 0, 0, 0, 0, 0,
                                        PREFIX_NONE));
        table_texts.push_back("123");
        // plus wins over space
        table_items.push_back(make_item(64'd42, 1, RADIX_DEC, 0, 0, 0, 0, 0, 1, 1, 0,
                                        PREFIX_NONE));
        table_texts.push_back("+42");
        table_items.push_back(make_item(64'd42, 1, RADIX_DEC, 0, 0, 0, 0, 0, 0, 1, 0,
                                        PREFIX_NONE));
        table_texts.push_back(" 42");
        // signed mode ignores the prefix code, unsigned ignores plus and space
        table_items.push_back(make_item(64'd42, 1, RADIX_HEX, 0, 0, 0, 0, 0, 0, 0, 0,
                                        PREFIX_HEX_LOWER));
        table_texts.push_back("2a");
        table_items.push_back(make_item(64'd42, 0, RADIX_DEC, 0, 0, 0, 0, 0, 1, 1, 0,
                                        PREFIX_NONE));
        table_texts.push_back("42");
        table_items.push_back(make_item(-64'd42, 1, RADIX_DEC, 0, 10, 0, 0, 0, 0, 0, 1,
                                        PREFIX_NONE));
        table_texts.push_back("");
        table_items.push_back(make_item(-64'd42, 1, RADIX_DEC, 0, 10, 0, 0, 1, 0, 0, 1,
                                        PREFIX_NONE));
        table_texts.push_back("");
        table_items.push_back(make_item(64'd255, 0, RADIX_HEX, 1, 12, 6, 1, 0, 0, 0, 1,
                                        PREFIX_HEX_LOWER));
        table_texts.push_back("");
        // width and precision above the limit saturate
        table_items.push_back(make_item(64'd7, 0, RADIX_DEC, 0, 63, 0, 0, 0, 0, 0, 0,
                                        PREFIX_NONE));
        table_texts.push_back("");
        table_items.push_back(make_item(64'd7, 1, RADIX_DEC, 0, 0, 63, 1, 0, 1, 0, 0,
                                        PREFIX_NONE));
        table_texts.push_back("");
        // longest text: two prefix characters and 62 digits
        table_items.push_back(make_item(64'hFFFF_FFFF_FFFF_FFFF, 0, RADIX_HEX, 0, 63, 63, 1,
                                        0, 0, 0, 0, PREFIX_HEX_UPPER));
        table_texts.push_back("");
        table_items.push_back(make_item(64'd0, 1, RADIX_DEC, 0, 62, 0, 0, 1, 0, 1, 1,
                                        PREFIX_NONE));
        table_texts.push_back("");
        table_items.push_back(make_item(64'd1, 0, RADIX_OCT, 0, 5, 0, 0, 0, 0, 0, 1,
                                        PREFIX_OCTAL));
        table_texts.push_back("");
        table_items.push_back(make_item(64'h8000_0000_0000_0000, 0, RADIX_DEC, 0, 20, 25, 1,
                                        0, 0, 0, 1, PREFIX_NONE));
        table_texts.push_back("");

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < table_items.size(); k++)
            send_item(table_items[k], table_texts[k], 1'b1);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            steady = (k >= STEADY_FROM && k < STEADY_TO);
            if (k == PAUSE_AT)
            begin
                // let the block run dry before offering more
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (expected_text.size() != 0)
                    @(posedge clk);
                send_item(random_item(), "", 1'b0);
            end
            else
            begin
                send_item(random_item(), "", 1'b1);
            end
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d values (%0d from the table) and %0d characters",
                 accepted_items, table_items.size(), chars_checked);
        $display("signed %0d, hex %0d, octal %0d, radix code three %0d",
                 signed_items, hex_items, oct_items, odd_radix_items);
        if (error_count == 0)
            $display("** integer_text_formatter_core: PASSED **");
        else
            $display("** integer_text_formatter_core: FAILED **");
        $finish;
    end

endmodule
